### rtl/core/msa_pkg.sv
// shared constants, codes and address helpers for the matrix store alu
package msa_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_DIM     = 8;
  localparam int DEFAULT_DIM = 3;
  localparam int RESET_DIM   = (DEFAULT_DIM > MAX_DIM) ? MAX_DIM : DEFAULT_DIM;

  localparam int SLOT_CELLS  = MAX_DIM * MAX_DIM;
  localparam int TOTAL_CELLS = NUM_SLOTS * SLOT_CELLS;

  localparam int WORD_W   = 32;
  localparam int FIELD_W  = 3;   // slot, row and col fields
  localparam int DIM_W    = 4;   // shape fields
  localparam int ACT_W    = 4;
  localparam int STATUS_W = 2;

  localparam int SEL_W  = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int CELL_W = $clog2(SLOT_CELLS);
  localparam int ADDR_W = $clog2(TOTAL_CELLS);

  typedef enum logic [ACT_W-1:0] {
    ACT_SHAPE = 4'd0,
    ACT_WRITE = 4'd1,
    ACT_READ  = 4'd2,
    ACT_ADD   = 4'd3,
    ACT_MUL   = 4'd4,
    ACT_SCALE = 4'd5,
    ACT_TRANS = 4'd6,
    ACT_CLEAR = 4'd7,
    ACT_SWAP  = 4'd8
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SHAPE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SHA, S_SHB, S_CHECK, S_RDCAP,
    S_CALC, S_COMMIT, S_CLR, S_SWAP, S_SWPSH, S_DONE
  } state_e;

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SEL_W-1:0] s);
    slot_base = ADDR_W'(s) * ADDR_W'(SLOT_CELLS);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [SEL_W-1:0] s,
                                                  input logic [CNT_W-1:0] r,
                                                  input logic [CNT_W-1:0] c);
    cell_addr = slot_base(s) + ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  function automatic logic [CELL_W-1:0] scr_addr(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
    scr_addr = CELL_W'(r) * CELL_W'(MAX_DIM) + CELL_W'(c);
  endfunction

  function automatic logic [DIM_W-1:0] span(input logic [DIM_W-1:0] d);
    span = (d == '0) ? DIM_W'(1) : d;
  endfunction

endpackage

### rtl/core/matrix_store_alu_top.sv
// matrix store alu: slot file of small integer matrices with element alu
// One request at a time: a request is taken when start is high and busy is low, and its
// single result word appears on the result ports for one cycle with done_o high; the
// receiver cannot stall it. All elements live in one single-port-read memory of
// NUM_SLOTS*MAX_DIM*MAX_DIM words plus a MAX_DIM*MAX_DIM scratch memory, both with a
// registered read. Add, scale and transpose walk each source element through a
// four-phase read/compute/accumulate sequence and then copy each destination element
// from scratch; multiply runs that sequence once per multiply-accumulate step
// (height*width*inner). Clear walks SLOT_CELLS words and swap walks SLOT_CELLS pairs.
// After reset the block runs a clearing pass over all TOTAL_CELLS (512) words of the
// element memory with busy high.
module matrix_store_alu_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [msa_pkg::ACT_W-1:0]           action_i,
  input  logic [msa_pkg::FIELD_W-1:0]         slot_a_i,
  input  logic [msa_pkg::FIELD_W-1:0]         slot_b_i,
  input  logic [msa_pkg::FIELD_W-1:0]         slot_dest_i,
  input  logic [msa_pkg::FIELD_W-1:0]         row_i,
  input  logic [msa_pkg::FIELD_W-1:0]         col_i,
  input  logic [msa_pkg::DIM_W-1:0]           new_height_i,
  input  logic [msa_pkg::DIM_W-1:0]           new_width_i,
  input  logic signed [msa_pkg::WORD_W-1:0]   value_i,
  output logic                                done_o,
  output logic [msa_pkg::STATUS_W-1:0]        status_o,
  output logic signed [msa_pkg::WORD_W-1:0]   read_value_o,
  output logic [msa_pkg::DIM_W-1:0]           result_height_o,
  output logic [msa_pkg::DIM_W-1:0]           result_width_o
);

  localparam int DW = msa_pkg::DIM_W;
  localparam int WW = msa_pkg::WORD_W;
  localparam int SW = msa_pkg::SEL_W;
  localparam int CW = msa_pkg::CNT_W;
  localparam int AW = msa_pkg::ADDR_W;

  msa_pkg::state_e state_q, state_d;

  // request fields
  logic [msa_pkg::ACT_W-1:0]   act_q;
  logic [msa_pkg::FIELD_W-1:0] a_q, b_q, d_q, row_q, col_q;
  logic [DW-1:0]               nh_q, nw_q;
  logic [WW-1:0]               val_q;

  logic [DW-1:0] ha_q, wa_q, hb_q, wb_q;
  logic [SW-1:0] sl1_q, sl2_q;
  logic [DW-1:0] rmax_q, cmax_q, kmax_q;
  logic [CW-1:0] r_q, c_q, k_q;
  logic [1:0]    ph_q;
  logic [AW-1:0] cnt_q;
  logic [WW-1:0] opa_q, res_q, acc_q;

  msa_pkg::status_e status_q;
  logic [WW-1:0]    rv_q;
  logic [DW-1:0]    rh_q, rw_q;

  // shape file
  logic [DW-1:0] sh_h_q [msa_pkg::NUM_SLOTS];
  logic [DW-1:0] sh_w_q [msa_pkg::NUM_SLOTS];
  logic          sh_we;
  logic [SW-1:0] sh_wa;
  logic [DW-1:0] sh_wh, sh_ww;

  // element and scratch memories
  logic [WW-1:0] emem [msa_pkg::TOTAL_CELLS];
  logic [WW-1:0] smem [msa_pkg::SLOT_CELLS];
  logic          e_we, s_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [WW-1:0] e_wdata, e_rdata_q, s_wdata, s_rdata_q;
  logic [msa_pkg::CELL_W-1:0] s_waddr, s_raddr;

  // check results
  logic              a_ok, b_ok, d_ok, sc_a, sc_b;
  msa_pkg::status_e  chk_status;
  logic [DW-1:0]     chk_rh, chk_rw;
  logic              is_add, is_mul, is_trans;
  logic              last_r, last_c, last_k, last_slot, last_all;
  logic [WW-1:0]     accv;
  logic [WW-1:0]     prod;

  assign a_ok = int'(a_q) < msa_pkg::NUM_SLOTS;
  assign b_ok = int'(b_q) < msa_pkg::NUM_SLOTS;
  assign d_ok = int'(d_q) < msa_pkg::NUM_SLOTS;
  assign sc_a = (ha_q == '0) && (wa_q == '0);
  assign sc_b = (hb_q == '0) && (wb_q == '0);

  assign is_add   = act_q == msa_pkg::ACT_ADD;
  assign is_mul   = act_q == msa_pkg::ACT_MUL;
  assign is_trans = act_q == msa_pkg::ACT_TRANS;

  assign last_r    = DW'(r_q) == rmax_q - DW'(1);
  assign last_c    = DW'(c_q) == cmax_q - DW'(1);
  assign last_k    = DW'(k_q) == kmax_q - DW'(1);
  assign last_slot = cnt_q == AW'(msa_pkg::SLOT_CELLS - 1);
  assign last_all  = cnt_q == AW'(msa_pkg::TOTAL_CELLS - 1);

  // products wrap at the word width
  assign prod = opa_q * e_rdata_q;
  assign accv = (is_mul ? acc_q : '0) + res_q;

  // request checks
  always_comb begin
    chk_status = msa_pkg::ST_OK;
    chk_rh     = '0;
    chk_rw     = '0;
    unique case (act_q)
      msa_pkg::ACT_SHAPE: begin
        if (!a_ok || !((nh_q == '0 && nw_q == '0) ||
            (nh_q != '0 && int'(nh_q) <= msa_pkg::MAX_DIM &&
             nw_q != '0 && int'(nw_q) <= msa_pkg::MAX_DIM))) begin
          chk_status = msa_pkg::ST_RANGE;
        end
        chk_rh = nh_q;
        chk_rw = nw_q;
      end
      msa_pkg::ACT_WRITE, msa_pkg::ACT_READ: begin
        if (!a_ok || DW'(row_q) >= msa_pkg::span(ha_q) ||
            DW'(col_q) >= msa_pkg::span(wa_q) ||
            (!sc_a && (ha_q == '0 || wa_q == '0))) begin
          chk_status = msa_pkg::ST_RANGE;
        end
        chk_rh = ha_q;
        chk_rw = wa_q;
      end
      msa_pkg::ACT_ADD: begin
        if (!a_ok || !b_ok || !d_ok) begin
          chk_status = msa_pkg::ST_RANGE;
        end else if (ha_q != hb_q || wa_q != wb_q) begin
          chk_status = msa_pkg::ST_SHAPE;
        end
        chk_rh = ha_q;
        chk_rw = wa_q;
      end
      msa_pkg::ACT_MUL: begin
        if (!a_ok || !b_ok || !d_ok) begin
          chk_status = msa_pkg::ST_RANGE;
        end else if (wa_q != hb_q || ha_q == '0 || wa_q == '0 || wb_q == '0) begin
          chk_status = msa_pkg::ST_SHAPE;
        end
        chk_rh = ha_q;
        chk_rw = wb_q;
      end
      msa_pkg::ACT_SCALE: begin
        if (!a_ok || !b_ok || !d_ok) begin
          chk_status = msa_pkg::ST_RANGE;
        end else if (sc_a == sc_b) begin
          chk_status = msa_pkg::ST_SHAPE;
        end
        chk_rh = sc_b ? ha_q : hb_q;
        chk_rw = sc_b ? wa_q : wb_q;
      end
      msa_pkg::ACT_TRANS: begin
        if (!a_ok || !d_ok) begin
          chk_status = msa_pkg::ST_RANGE;
        end
        chk_rh = wa_q;
        chk_rw = ha_q;
      end
      msa_pkg::ACT_CLEAR: begin
        if (!a_ok) begin
          chk_status = msa_pkg::ST_RANGE;
        end
        chk_rh = DW'(msa_pkg::RESET_DIM);
        chk_rw = DW'(msa_pkg::RESET_DIM);
      end
      msa_pkg::ACT_SWAP: begin
        if (!a_ok || !b_ok) begin
          chk_status = msa_pkg::ST_RANGE;
        end
        chk_rh = (a_q == b_q) ? ha_q : hb_q;
        chk_rw = (a_q == b_q) ? wa_q : wb_q;
      end
      default: begin
        chk_status = msa_pkg::ST_RANGE;
      end
    endcase
  end

  // next state and memory controls
  always_comb begin
    state_d = state_q;
    busy    = state_q != msa_pkg::S_IDLE;
    done_o  = 1'b0;
    e_we    = 1'b0;
    e_waddr = '0;
    e_wdata = '0;
    e_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = accv;
    s_raddr = '0;
    sh_we   = 1'b0;
    sh_wa   = SW'(a_q);
    sh_wh   = DW'(msa_pkg::RESET_DIM);
    sh_ww   = DW'(msa_pkg::RESET_DIM);
    unique case (state_q)
      msa_pkg::S_INIT: begin
        e_we    = 1'b1;
        e_waddr = cnt_q;
        if (last_all) begin
          state_d = msa_pkg::S_IDLE;
        end
      end
      msa_pkg::S_IDLE: begin
        if (start) begin
          state_d = msa_pkg::S_SHA;
        end
      end
      msa_pkg::S_SHA: state_d = msa_pkg::S_SHB;
      msa_pkg::S_SHB: state_d = msa_pkg::S_CHECK;
      msa_pkg::S_CHECK: begin
        e_raddr = msa_pkg::cell_addr(SW'(a_q), CW'(row_q), CW'(col_q));
        if (chk_status != msa_pkg::ST_OK) begin
          state_d = msa_pkg::S_DONE;
        end else begin
          unique case (act_q)
            msa_pkg::ACT_SHAPE: begin
              sh_we   = 1'b1;
              sh_wh   = nh_q;
              sh_ww   = nw_q;
              state_d = msa_pkg::S_DONE;
            end
            msa_pkg::ACT_WRITE: begin
              e_we    = 1'b1;
              e_waddr = e_raddr;
              e_wdata = val_q;
              state_d = msa_pkg::S_DONE;
            end
            msa_pkg::ACT_READ:  state_d = msa_pkg::S_RDCAP;
            msa_pkg::ACT_CLEAR: state_d = msa_pkg::S_CLR;
            msa_pkg::ACT_SWAP:  state_d = (a_q == b_q) ? msa_pkg::S_DONE : msa_pkg::S_SWAP;
            default:            state_d = msa_pkg::S_CALC;
          endcase
        end
      end
      msa_pkg::S_RDCAP: state_d = msa_pkg::S_DONE;
      msa_pkg::S_CALC: begin
        case (ph_q)
          2'd0: e_raddr = msa_pkg::cell_addr(sl1_q, r_q, is_mul ? k_q : c_q);
          2'd1: begin
            if (is_add) begin
              e_raddr = msa_pkg::cell_addr(sl2_q, r_q, c_q);
            end else if (is_mul) begin
              e_raddr = msa_pkg::cell_addr(sl2_q, k_q, c_q);
            end else begin
              e_raddr = msa_pkg::cell_addr(sl2_q, '0, '0);
            end
          end
          2'd2: ;
          default: begin
            if (last_k) begin
              s_we    = 1'b1;
              s_waddr = is_trans ? msa_pkg::scr_addr(c_q, r_q) : msa_pkg::scr_addr(r_q, c_q);
              if (last_c && last_r) begin
                state_d = msa_pkg::S_COMMIT;
              end
            end
          end
        endcase
      end
      msa_pkg::S_COMMIT: begin
        s_raddr = msa_pkg::scr_addr(r_q, c_q);
        if (ph_q[0]) begin
          e_we    = 1'b1;
          e_waddr = msa_pkg::cell_addr(SW'(d_q), r_q, c_q);
          e_wdata = s_rdata_q;
          if (last_c && last_r) begin
            sh_we   = 1'b1;
            sh_wa   = SW'(d_q);
            sh_wh   = rh_q;
            sh_ww   = rw_q;
            state_d = msa_pkg::S_DONE;
          end
        end
      end
      msa_pkg::S_CLR: begin
        e_we    = 1'b1;
        e_waddr = msa_pkg::slot_base(SW'(a_q)) + cnt_q;
        if (last_slot) begin
          sh_we   = 1'b1;
          state_d = msa_pkg::S_DONE;
        end
      end
      msa_pkg::S_SWAP: begin
        case (ph_q)
          2'd0: e_raddr = msa_pkg::slot_base(SW'(a_q)) + cnt_q;
          2'd1: e_raddr = msa_pkg::slot_base(SW'(b_q)) + cnt_q;
          2'd2: begin
            e_we    = 1'b1;
            e_waddr = msa_pkg::slot_base(SW'(a_q)) + cnt_q;
            e_wdata = e_rdata_q;
          end
          default: begin
            e_we    = 1'b1;
            e_waddr = msa_pkg::slot_base(SW'(b_q)) + cnt_q;
            e_wdata = opa_q;
            if (last_slot) begin
              sh_we   = 1'b1;
              sh_wh   = hb_q;
              sh_ww   = wb_q;
              state_d = msa_pkg::S_SWPSH;
            end
          end
        endcase
      end
      msa_pkg::S_SWPSH: begin
        sh_we   = 1'b1;
        sh_wa   = SW'(b_q);
        sh_wh   = ha_q;
        sh_ww   = wa_q;
        state_d = msa_pkg::S_DONE;
      end
      msa_pkg::S_DONE: begin
        done_o  = 1'b1;
        state_d = msa_pkg::S_IDLE;
      end
      default: state_d = msa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msa_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msa_pkg::NUM_SLOTS; i++) begin
        sh_h_q[i] <= DW'(msa_pkg::RESET_DIM);
        sh_w_q[i] <= DW'(msa_pkg::RESET_DIM);
      end
    end else if (sh_we) begin
      sh_h_q[sh_wa] <= sh_wh;
      sh_w_q[sh_wa] <= sh_ww;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      emem[e_waddr] <= e_wdata;
    end
    e_rdata_q <= emem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata_q <= smem[s_raddr];
  end

  // sweep counter: init pass, clear and swap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == msa_pkg::S_INIT || state_q == msa_pkg::S_CLR ||
                 (state_q == msa_pkg::S_SWAP && ph_q == 2'd3)) begin
      cnt_q <= (last_all || (state_q != msa_pkg::S_INIT && last_slot)) ? '0 : cnt_q + AW'(1);
    end
  end

  // datapath and loop counters
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      msa_pkg::S_IDLE: begin
        act_q <= action_i;
        a_q   <= slot_a_i;
        b_q   <= slot_b_i;
        d_q   <= slot_dest_i;
        row_q <= row_i;
        col_q <= col_i;
        nh_q  <= new_height_i;
        nw_q  <= new_width_i;
        val_q <= value_i;
      end
      msa_pkg::S_SHA: begin
        ha_q <= sh_h_q[SW'(a_q)];
        wa_q <= sh_w_q[SW'(a_q)];
      end
      msa_pkg::S_SHB: begin
        hb_q <= sh_h_q[SW'(b_q)];
        wb_q <= sh_w_q[SW'(b_q)];
      end
      msa_pkg::S_CHECK: begin
        status_q <= chk_status;
        rv_q     <= '0;
        rh_q     <= (chk_status == msa_pkg::ST_OK) ? chk_rh : '0;
        rw_q     <= (chk_status == msa_pkg::ST_OK) ? chk_rw : '0;
        r_q      <= '0;
        c_q      <= '0;
        k_q      <= '0;
        ph_q     <= '0;
        acc_q    <= '0;
        // scale streams the matrix operand first, the scalar second
        sl1_q    <= (act_q == msa_pkg::ACT_SCALE && !sc_b) ? SW'(b_q) : SW'(a_q);
        sl2_q    <= (act_q == msa_pkg::ACT_SCALE && !sc_b) ? SW'(a_q) : SW'(b_q);
        kmax_q   <= (act_q == msa_pkg::ACT_MUL) ? wa_q : DW'(1);
        if (act_q == msa_pkg::ACT_MUL) begin
          rmax_q <= ha_q;
          cmax_q <= wb_q;
        end else if (act_q == msa_pkg::ACT_SCALE) begin
          rmax_q <= msa_pkg::span(chk_rh);
          cmax_q <= msa_pkg::span(chk_rw);
        end else begin
          rmax_q <= msa_pkg::span(ha_q);
          cmax_q <= msa_pkg::span(wa_q);
        end
      end
      msa_pkg::S_RDCAP: rv_q <= e_rdata_q;
      msa_pkg::S_CALC: begin
        ph_q <= ph_q + 2'd1;
        case (ph_q)
          2'd1: opa_q <= e_rdata_q;
          2'd2: begin
            if (is_add) begin
              res_q <= opa_q + e_rdata_q;
            end else if (is_trans) begin
              res_q <= opa_q;
            end else begin
              res_q <= prod;
            end
          end
          2'd3: begin
            if (!last_k) begin
              acc_q <= accv;
              k_q   <= k_q + CW'(1);
            end else begin
              acc_q <= '0;
              k_q   <= '0;
              if (!last_c) begin
                c_q <= c_q + CW'(1);
              end else begin
                c_q <= '0;
                if (last_r) begin
                  // commit walks the destination shape
                  r_q    <= '0;
                  rmax_q <= msa_pkg::span(rh_q);
                  cmax_q <= msa_pkg::span(rw_q);
                end else begin
                  r_q <= r_q + CW'(1);
                end
              end
            end
          end
          default: ;
        endcase
      end
      msa_pkg::S_COMMIT: begin
        ph_q <= {1'b0, ~ph_q[0]};
        if (ph_q[0]) begin
          if (!last_c) begin
            c_q <= c_q + CW'(1);
          end else begin
            c_q <= '0;
            r_q <= r_q + CW'(1);
          end
        end
      end
      msa_pkg::S_SWAP: begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd1) begin
          opa_q <= e_rdata_q;
        end
      end
      default: ;
    endcase
  end

  assign status_o        = status_q;
  assign read_value_o    = rv_q;
  assign result_height_o = rh_q;
  assign result_width_o  = rw_q;

`ifndef NO_ASSERTIONS
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("result strobe not followed by idle");

  a_error_clears_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != msa_pkg::ST_OK) |->
      (result_height_o == '0 && result_width_o == '0 && read_value_o == '0))
    else $error("error result carries data");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted word did not start work");
`endif

endmodule
